[hw/rtl/glip_pkg.sv]
// Shared constants and handshake structs for the grid longest increasing path block.
// No dependencies; used by glip_walk and grid_longest_increasing_path.
package glip_pkg;

	localparam int MAX_DIM_DEF = 64;
	localparam int VAL_W       = 32;
	localparam int OUT_W       = 13;
	localparam int CFG_W       = 7;
	localparam int CFG_IDX_W   = 1;
	localparam int TDATA_IN_W  = 32;
	localparam int TDATA_OUT_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'd1;
	localparam logic [CFG_W-1:0]     DIM_RESET     = 7'd64;

	// neighbor directions, DIR_END means all four were scanned
	localparam logic [2:0] DIR_UP    = 3'd0;
	localparam logic [2:0] DIR_DOWN  = 3'd1;
	localparam logic [2:0] DIR_LEFT  = 3'd2;
	localparam logic [2:0] DIR_RIGHT = 3'd3;
	localparam logic [2:0] DIR_END   = 3'd4;

	typedef struct packed {
		logic start;   // grid fully loaded, begin the walk
		logic ack;     // result taken, return to idle
	} walk_ctrl_t;

	typedef struct packed {
		logic done;    // walk finished, best length valid
	} walk_stat_t;

endpackage

[hw/rtl/glip_walk.sv]
// Memo walk engine: grid, memo and stack memories plus the depth-first sequencer.
// Depends on glip_pkg.
module glip_walk #(
	parameter int MAX_DIM = glip_pkg::MAX_DIM_DEF,
	parameter int CELLS   = MAX_DIM * MAX_DIM,
	parameter int CELL_W  = (CELLS > 1) ? $clog2(CELLS) : 1,
	parameter int TOT_W   = CELL_W + 1,
	parameter int DIM_W   = $clog2(MAX_DIM + 1),
	parameter int LEN_W   = $clog2(CELLS + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  glip_pkg::walk_ctrl_t           ctrl,
	output glip_pkg::walk_stat_t           stat,
	input  logic [DIM_W-1:0]               rows,
	input  logic [DIM_W-1:0]               cols,
	input  logic [TOT_W-1:0]               total,
	input  logic                           ld_en,
	input  logic [CELL_W-1:0]              ld_addr,
	input  logic signed [glip_pkg::VAL_W-1:0] ld_data,
	output logic [LEN_W-1:0]               best
);
	import glip_pkg::*;

	localparam int ROW_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	typedef struct packed {
		logic [CELL_W-1:0]       node;
		logic [ROW_W-1:0]        row;
		logic [ROW_W-1:0]        col;
		logic [1:0]              dir;
		logic [LEN_W-1:0]        len;
		logic signed [VAL_W-1:0] val;
	} frame_t;

	typedef enum logic [6:0] {
		W_IDLE     = 7'b0000001,
		W_START    = 7'b0000010,
		W_START_RD = 7'b0000100,
		W_DIR      = 7'b0001000,
		W_NB       = 7'b0010000,
		W_POP      = 7'b0100000,
		W_DONE     = 7'b1000000
	} wstate_t;

	// memories
	logic signed [VAL_W-1:0] grid_mem  [CELLS];
	logic [LEN_W-1:0]        memo_mem  [CELLS];
	frame_t                  stack_mem [CELLS];

	logic signed [VAL_W-1:0] grid_rd_q;
	logic [LEN_W-1:0]        memo_rd_q;
	frame_t                  stack_rd_q;

	wstate_t           state_q;
	logic [TOT_W-1:0]  start_q;
	logic [ROW_W-1:0]  start_row_q, start_col_q;
	logic [TOT_W-1:0]  sp_q;
	logic [LEN_W-1:0]  best_q;
	frame_t            cur_q;
	logic [2:0]        dir_q;
	logic [CELL_W-1:0] nb_cell_q;
	logic [ROW_W-1:0]  nb_row_q, nb_col_q;

	// comb control
	logic [CELL_W-1:0] rd_addr;
	logic              memo_we;
	logic              push_we;
	logic [CELL_W-1:0] pop_addr;
	logic              inb;
	logic [CELL_W-1:0] nb_cell;
	logic [ROW_W-1:0]  nb_row, nb_col;
	logic [DIM_W-1:0]  row_x, col_x;
	logic              col_last;

	assign row_x    = DIM_W'(cur_q.row);
	assign col_x    = DIM_W'(cur_q.col);
	assign col_last = (DIM_W'(start_col_q) == cols - DIM_W'(1));
	assign pop_addr = CELL_W'(sp_q - TOT_W'(1));

	// neighbor bounds and address for the direction under scan
	always_comb begin
		inb     = 1'b0;
		nb_cell = cur_q.node;
		nb_row  = cur_q.row;
		nb_col  = cur_q.col;
		unique case (dir_q)
			DIR_UP: begin
				inb     = (cur_q.row != '0);
				nb_cell = cur_q.node - CELL_W'(cols);
				nb_row  = cur_q.row - ROW_W'(1);
			end
			DIR_DOWN: begin
				inb     = (row_x + DIM_W'(1) < rows);
				nb_cell = cur_q.node + CELL_W'(cols);
				nb_row  = cur_q.row + ROW_W'(1);
			end
			DIR_LEFT: begin
				inb     = (cur_q.col != '0);
				nb_cell = cur_q.node - CELL_W'(1);
				nb_col  = cur_q.col - ROW_W'(1);
			end
			DIR_RIGHT: begin
				inb     = (col_x + DIM_W'(1) < cols);
				nb_cell = cur_q.node + CELL_W'(1);
				nb_col  = cur_q.col + ROW_W'(1);
			end
			default: inb = 1'b0;
		endcase
	end

	// read address and write strobes
	always_comb begin
		rd_addr = nb_cell;
		memo_we = 1'b0;
		push_we = 1'b0;
		if (state_q == W_START) begin
			rd_addr = CELL_W'(start_q);
		end
		if (state_q == W_DIR && dir_q == DIR_END) begin
			memo_we = 1'b1;
		end
		if (state_q == W_NB && grid_rd_q > cur_q.val && memo_rd_q == '0 &&
				sp_q < TOT_W'(CELLS)) begin
			push_we = 1'b1;
		end
	end

	// grid store: written while loading, read by the walk
	always_ff @(posedge clk) begin
		if (ld_en) begin
			grid_mem[ld_addr] <= ld_data;
		end
		grid_rd_q <= grid_mem[rd_addr];
	end

	// memo: cleared entry by entry during the load, written on each finished cell
	always_ff @(posedge clk) begin
		if (ld_en) begin
			memo_mem[ld_addr] <= '0;
		end else if (memo_we) begin
			memo_mem[cur_q.node] <= cur_q.len;
		end
		memo_rd_q <= memo_mem[rd_addr];
	end

	// frame stack, top frame lives in cur_q
	always_ff @(posedge clk) begin
		if (push_we) begin
			stack_mem[CELL_W'(sp_q)] <= '{node: cur_q.node, row: cur_q.row, col: cur_q.col,
				dir: dir_q[1:0], len: cur_q.len, val: cur_q.val};
		end
		stack_rd_q <= stack_mem[pop_addr];
	end

	// walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= W_IDLE;
			start_q     <= '0;
			start_row_q <= '0;
			start_col_q <= '0;
			sp_q        <= '0;
			best_q      <= '0;
			dir_q       <= DIR_UP;
		end else begin
			unique case (state_q)
				W_IDLE: begin
					if (ctrl.start) begin
						start_q     <= '0;
						start_row_q <= '0;
						start_col_q <= '0;
						sp_q        <= '0;
						best_q      <= '0;
						state_q     <= W_START;
					end
				end
				W_START: begin
					if (start_q == total) begin
						state_q <= W_DONE;
					end else begin
						state_q <= W_START_RD;
					end
				end
				W_START_RD: begin
					if (memo_rd_q != '0) begin
						start_q <= start_q + TOT_W'(1);
						if (col_last) begin
							start_col_q <= '0;
							start_row_q <= start_row_q + ROW_W'(1);
						end else begin
							start_col_q <= start_col_q + ROW_W'(1);
						end
						state_q <= W_START;
					end else begin
						cur_q.node <= CELL_W'(start_q);
						cur_q.row  <= start_row_q;
						cur_q.col  <= start_col_q;
						cur_q.len  <= LEN_W'(1);
						cur_q.val  <= grid_rd_q;
						dir_q      <= DIR_UP;
						state_q    <= W_DIR;
					end
				end
				W_DIR: begin
					if (dir_q == DIR_END) begin
						// cell finished: memo written by strobe
						if (cur_q.len > best_q) begin
							best_q <= cur_q.len;
						end
						if (sp_q == '0) begin
							start_q <= start_q + TOT_W'(1);
							if (col_last) begin
								start_col_q <= '0;
								start_row_q <= start_row_q + ROW_W'(1);
							end else begin
								start_col_q <= start_col_q + ROW_W'(1);
							end
							state_q <= W_START;
						end else begin
							sp_q    <= sp_q - TOT_W'(1);
							state_q <= W_POP;
						end
					end else if (inb) begin
						nb_cell_q <= nb_cell;
						nb_row_q  <= nb_row;
						nb_col_q  <= nb_col;
						state_q   <= W_NB;
					end else begin
						dir_q <= dir_q + 3'd1;
					end
				end
				W_NB: begin
					state_q <= W_DIR;
					if (push_we) begin
						// descend; parent rescans this direction on return
						sp_q       <= sp_q + TOT_W'(1);
						cur_q.node <= nb_cell_q;
						cur_q.row  <= nb_row_q;
						cur_q.col  <= nb_col_q;
						cur_q.len  <= LEN_W'(1);
						cur_q.val  <= grid_rd_q;
						dir_q      <= DIR_UP;
					end else begin
						if (grid_rd_q > cur_q.val && memo_rd_q != '0 &&
								memo_rd_q + LEN_W'(1) > cur_q.len) begin
							cur_q.len <= memo_rd_q + LEN_W'(1);
						end
						dir_q <= dir_q + 3'd1;
					end
				end
				W_POP: begin
					cur_q   <= stack_rd_q;
					dir_q   <= {1'b0, stack_rd_q.dir};
					state_q <= W_DIR;
				end
				W_DONE: begin
					if (ctrl.ack) begin
						state_q <= W_IDLE;
					end
				end
				default: state_q <= W_IDLE;
			endcase
		end
	end

	assign stat.done = (state_q == W_DONE);
	assign best      = best_q;

endmodule

[hw/rtl/grid_longest_increasing_path.sv]
// Grid longest increasing path: top level with config, cell loading and result register.
// Depends on glip_pkg and glip_walk.
// Loading takes one cell per cycle while s_tready is high; after the last cell the
// depth-first walk runs, paced by the single read port of the grid/memo memories:
// each neighbor probe reads both, plus start, push and pop steps.
// Throughput: one grid at a time; the next grid loads while a result waits.
// Reset: arst_n clears control, sizes go to 64 by 64, memories are not cleared.
module grid_longest_increasing_path #(
	parameter int MAX_DIM = glip_pkg::MAX_DIM_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [glip_pkg::TDATA_IN_W-1:0]      s_tdata,   // [31:0] cell_value
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [glip_pkg::TDATA_OUT_W-1:0]     m_tdata,   // [12:0] longest_path
	input  logic                                 cfg_we,
	input  logic [glip_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [glip_pkg::CFG_W-1:0]           cfg_wdata
);
	import glip_pkg::*;

	localparam int CELLS  = MAX_DIM * MAX_DIM;
	localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int TOT_W  = CELL_W + 1;
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int LEN_W  = $clog2(CELLS + 1);

	typedef enum logic [1:0] {
		T_LOAD = 2'b01,
		T_WALK = 2'b10
	} tstate_t;

	tstate_t           tstate_q;
	logic [CFG_W-1:0]  rows_q, cols_q;
	logic [TOT_W-1:0]  load_q;
	logic [OUT_W-1:0]  out_q;
	logic              out_valid_q;

	logic [DIM_W-1:0]  rows, cols;
	logic [TOT_W-1:0]  total;
	logic [CELL_W-1:0] ld_addr;
	logic              in_acc;
	logic              last_cell;
	walk_ctrl_t        ctrl;
	walk_stat_t        stat;
	logic [LEN_W-1:0]  best;

	// clamp sizes into 1..MAX_DIM
	always_comb begin
		if (rows_q == '0) rows = DIM_W'(1);
		else if (32'(rows_q) > MAX_DIM) rows = DIM_W'(MAX_DIM);
		else rows = DIM_W'(rows_q);
		if (cols_q == '0) cols = DIM_W'(1);
		else if (32'(cols_q) > MAX_DIM) cols = DIM_W'(MAX_DIM);
		else cols = DIM_W'(cols_q);
	end

	assign total     = TOT_W'(rows) * TOT_W'(cols);
	assign ld_addr   = (load_q >= total) ? '0 : CELL_W'(load_q);
	assign s_tready  = (tstate_q == T_LOAD);
	assign in_acc    = s_tvalid && s_tready;
	assign last_cell = (TOT_W'(ld_addr) + TOT_W'(1) >= total);

	assign ctrl.start = in_acc && last_cell;
	assign ctrl.ack   = stat.done && (!out_valid_q || m_tready);

	// config, loading and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tstate_q    <= T_LOAD;
			rows_q      <= DIM_RESET;
			cols_q      <= DIM_RESET;
			load_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ROW_COUNT: rows_q <= cfg_wdata;
					CFG_COL_COUNT: cols_q <= cfg_wdata;
					default: ;
				endcase
				load_q <= '0;
			end else if (in_acc) begin
				if (last_cell) begin
					load_q   <= '0;
					tstate_q <= T_WALK;
				end else begin
					load_q <= TOT_W'(ld_addr) + TOT_W'(1);
				end
			end
			if (ctrl.ack) begin
				out_valid_q <= 1'b1;
				tstate_q    <= T_LOAD;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ack) begin
			out_q <= OUT_W'(best);
		end
	end

	glip_walk #(
		.MAX_DIM (MAX_DIM)
	) u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.stat    (stat),
		.rows    (rows),
		.cols    (cols),
		.total   (total),
		.ld_en   (in_acc),
		.ld_addr (ld_addr),
		.ld_data ($signed(s_tdata[VAL_W-1:0])),
		.best    (best)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_OUT_W - OUT_W){1'b0}}, out_q};

endmodule
